// File: src/bvi_pkg.sv
// ----------------------------------------------------------------------------
// bvi_pkg
// Shared types, widths and helpers for the unaligned bit vector insert block.
// ----------------------------------------------------------------------------
package bvi_pkg;

  localparam int WORD_BITS = 32;
  localparam int WORD_LOG  = $clog2(WORD_BITS);
  localparam int CFG_W     = 24;
  localparam int CNT_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_LEN  = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [CFG_W-1:0] start_bit;
    logic [CFG_W-1:0] bit_count;
    logic [CFG_W-1:0] dest_length_bits;
  } cfg_t;

  typedef struct packed {
    word_t            new_dest_word;
    logic [CNT_W-1:0] word_index;
    logic             last_word;
    logic             range_error;
  } res_t;

  // low n bits set, n in 0..WORD_BITS
  function automatic word_t ones(input logic [WORD_LOG:0] n);
    logic [WORD_BITS:0] t;
    t = ({{WORD_BITS{1'b0}}, 1'b1} << n) - {{WORD_BITS{1'b0}}, 1'b1};
    return t[WORD_BITS-1:0];
  endfunction

endpackage

// File: src/bvi_in_if.sv
// ----------------------------------------------------------------------------
// bvi_in_if
// Input item channel: next source word and old destination word.
// ----------------------------------------------------------------------------
interface bvi_in_if;
  logic                   valid;
  logic                   ready;
  logic [bvi_pkg::WORD_BITS-1:0] src_word;
  logic [bvi_pkg::WORD_BITS-1:0] old_dest_word;

  modport source (output valid, output src_word, output old_dest_word, input ready);
  modport sink   (input valid, input src_word, input old_dest_word, output ready);
endinterface

// File: src/bvi_out_if.sv
// ----------------------------------------------------------------------------
// bvi_out_if
// Result item channel: merged destination word, index and flags.
// ----------------------------------------------------------------------------
interface bvi_out_if;
  logic                          valid;
  logic                          ready;
  logic [bvi_pkg::WORD_BITS-1:0] new_dest_word;
  logic [bvi_pkg::CNT_W-1:0]     word_index;
  logic                          last_word;
  logic                          range_error;

  modport source (output valid, output new_dest_word, output word_index,
                  output last_word, output range_error, input ready);
  modport sink   (input valid, input new_dest_word, input word_index,
                  input last_word, input range_error, output ready);
endinterface

// File: src/bvi_cfg_if.sv
// ----------------------------------------------------------------------------
// bvi_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bvi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bvi_pkg::CFG_IDX_W-1:0] reg_index;
  logic [bvi_pkg::CFG_W-1:0]     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: src/bvi_cfg_regs.sv
// ----------------------------------------------------------------------------
// bvi_cfg_regs
// Configuration register file; flags a copy restart on any listed write.
// ----------------------------------------------------------------------------
module bvi_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  bvi_cfg_if.sink          cfg_ch,
  output bvi_pkg::cfg_t    cfg,
  output logic             restart
);

  bvi_pkg::cfg_t cfg_r;
  bvi_pkg::cfg_t cfg_nxt;
  logic          wr;
  logic          hit;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid & cfg_ch.ready;

  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b0;
    unique case (cfg_ch.reg_index)
      bvi_pkg::REG_START_BIT: begin
        cfg_nxt.start_bit = cfg_ch.wdata;
        hit = 1'b1;
      end
      bvi_pkg::REG_BIT_COUNT: begin
        cfg_nxt.bit_count = cfg_ch.wdata;
        hit = 1'b1;
      end
      bvi_pkg::REG_DEST_LEN: begin
        cfg_nxt.dest_length_bits = cfg_ch.wdata;
        hit = 1'b1;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg     = cfg_r;
  assign restart = wr & hit;

endmodule

// File: src/bvi_merge.sv
// ----------------------------------------------------------------------------
// bvi_merge
// Shift, carry and mask merge of one word, with the carry and word counter.
// ----------------------------------------------------------------------------
module bvi_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bvi_pkg::cfg_t         cfg,
  input  logic                  restart,
  input  logic                  advance,
  input  bvi_pkg::word_t        src_word,
  input  bvi_pkg::word_t        old_dest_word,
  output bvi_pkg::res_t         res
);

  localparam int EW = bvi_pkg::CFG_W + 1;
  localparam int TW = EW + 1 - bvi_pkg::WORD_LOG;
  localparam int BW = bvi_pkg::CNT_W + bvi_pkg::WORD_LOG;

  bvi_pkg::word_t                 spill_r, spill_nxt;
  logic [bvi_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [bvi_pkg::WORD_LOG-1:0]   pr;
  logic [EW-1:0]                  end_pos;
  logic [EW:0]                    round_up;
  logic [TW-1:0]                  total_raw, total, cnt_inc;
  logic                           last;
  logic [BW-1:0]                  end_ext, base, diff;
  logic [bvi_pkg::WORD_LOG:0]     hi, lo, sh;
  bvi_pkg::word_t                 mask, data, carry;
  logic                           err;

  always_comb begin
    pr        = cfg.start_bit[bvi_pkg::WORD_LOG-1:0];
    end_pos   = EW'(pr) + EW'(cfg.bit_count);
    round_up  = (EW+1)'(end_pos) + (EW+1)'(bvi_pkg::WORD_BITS - 1);
    total_raw = round_up[EW:bvi_pkg::WORD_LOG];
    total     = (total_raw == '0) ? TW'(1) : total_raw;
    cnt_inc   = TW'(cnt_r) + TW'(1);
    last      = (cnt_inc >= total);

    end_ext = BW'(end_pos);
    base    = {cnt_r, {bvi_pkg::WORD_LOG{1'b0}}};
    diff    = end_ext - base;
    if (end_ext <= base) begin
      hi = '0;
    end else if (diff >= BW'(bvi_pkg::WORD_BITS)) begin
      hi = (bvi_pkg::WORD_LOG+1)'(bvi_pkg::WORD_BITS);
    end else begin
      hi = diff[bvi_pkg::WORD_LOG:0];
    end
    lo   = (cnt_r == '0) ? {1'b0, pr} : '0;
    mask = bvi_pkg::ones(hi) & ~bvi_pkg::ones(lo);

    data  = (src_word << pr) | spill_r;
    sh    = (bvi_pkg::WORD_LOG+1)'(bvi_pkg::WORD_BITS) - {1'b0, pr};
    carry = (pr == '0) ? '0 : (src_word >> sh);

    err = ({1'b0, cfg.start_bit} + {1'b0, cfg.bit_count}) > {1'b0, cfg.dest_length_bits};

    res.new_dest_word = err ? old_dest_word : ((old_dest_word & ~mask) | (data & mask));
    res.word_index    = bvi_pkg::CNT_W'(cfg.start_bit >> bvi_pkg::WORD_LOG) + cnt_r;
    res.last_word     = last;
    res.range_error   = err;

    spill_nxt = spill_r;
    cnt_nxt   = cnt_r;
    if (restart) begin
      spill_nxt = '0;
      cnt_nxt   = '0;
    end else if (advance) begin
      if (last) begin
        spill_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        spill_nxt = carry;
        cnt_nxt   = cnt_r + bvi_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spill_r <= '0;
      cnt_r   <= '0;
    end else begin
      spill_r <= spill_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: src/unaligned_bit_vector_insert_core.sv
// ----------------------------------------------------------------------------
// unaligned_bit_vector_insert_core
// Streaming insert of a source bit vector at an unaligned destination offset.
// ----------------------------------------------------------------------------
// One item enters per clock while the output is not stalled; its merged
// destination word passes the input register, then the result register. The
// one-word carry register and word counter update as each item passes from the
// input register to the result register, the only item-to-item dependency.
// Start bit, bit count and destination length writes restart the copy sequence.
module unaligned_bit_vector_insert_core (
  input  logic     clk,
  input  logic     rst_n,
  bvi_in_if.sink   in_ch,
  bvi_out_if.source out_ch,
  bvi_cfg_if.sink  cfg_ch
);

  bvi_pkg::cfg_t  cfg;
  logic           restart;

  logic           s1_valid_r;
  bvi_pkg::word_t s1_src_r;
  bvi_pkg::word_t s1_old_r;
  logic           s1_adv;

  logic           out_valid_r, out_valid_nxt;
  bvi_pkg::res_t  out_res_r;
  bvi_pkg::res_t  res;

  bvi_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .cfg     (cfg),
    .restart (restart)
  );

  bvi_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .restart       (restart),
    .advance       (s1_adv),
    .src_word      (s1_src_r),
    .old_dest_word (s1_old_r),
    .res           (res)
  );

  assign s1_adv      = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_src_r <= in_ch.src_word;
      s1_old_r <= in_ch.old_dest_word;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.new_dest_word = out_res_r.new_dest_word;
  assign out_ch.word_index    = out_res_r.word_index;
  assign out_ch.last_word     = out_res_r.last_word;
  assign out_ch.range_error   = out_res_r.range_error;

endmodule

// File: src/bvi_checker.sv
// ----------------------------------------------------------------------------
// bvi_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module bvi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [bvi_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bvi_pkg::WORD_BITS-1:0] out_word,
  input logic [bvi_pkg::CNT_W-1:0]     out_index,
  input logic                          out_last
);

  logic                      out_acc;
  logic                      cfg_restart;
  logic                      seen_r;
  logic                      prev_last_r;
  logic [bvi_pkg::CNT_W-1:0] prev_idx_r;
  logic [bvi_pkg::CNT_W-1:0] first_idx_r;

  assign out_acc     = out_valid & out_ready;
  assign cfg_restart = cfg_valid & cfg_ready &
                       ((cfg_index == bvi_pkg::REG_START_BIT) |
                        (cfg_index == bvi_pkg::REG_BIT_COUNT) |
                        (cfg_index == bvi_pkg::REG_DEST_LEN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      prev_last_r <= 1'b0;
      prev_idx_r  <= '0;
      first_idx_r <= '0;
    end else if (cfg_restart) begin
      seen_r <= 1'b0;
    end else if (out_acc) begin
      seen_r      <= 1'b1;
      prev_last_r <= out_last;
      prev_idx_r  <= out_index;
      if (!seen_r || prev_last_r) begin
        first_idx_r <= out_index;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word) && $stable(out_index) && $stable(out_last))
    else $error("result item changed while stalled");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r && !prev_last_r |-> out_index == prev_idx_r + bvi_pkg::CNT_W'(1))
    else $error("word index did not advance by one");

  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r && prev_last_r |-> out_index == first_idx_r)
    else $error("copy did not restart at its first word");

endmodule

bind unaligned_bit_vector_insert_core bvi_checker u_bvi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready),
  .cfg_index (cfg_ch.reg_index),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.new_dest_word),
  .out_index (out_ch.word_index),
  .out_last  (out_ch.last_word)
);
